// ===== rtl/core/hsv_to_rgb565_top_macros.svh =====
// ----------------------------------------------------------------------------
// HSV to RGB565 assertion macros
// Property wrappers shared by the converter RTL; empty bodies in synthesis.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB565_TOP_MACROS_SVH
`define HSV_TO_RGB565_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked while reset is released.
`define HSV565_ASSERT_IMP(lbl, ck, rn, ant, con) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ant) |-> (con)) \
		else $error("implication check failed");
// Next-cycle implication, checked while reset is released.
`define HSV565_ASSERT_NXT(lbl, ck, rn, ant, con) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ant) |=> (con)) \
		else $error("next-cycle check failed");
`else
`define HSV565_ASSERT_IMP(lbl, ck, rn, ant, con)
`define HSV565_ASSERT_NXT(lbl, ck, rn, ant, con)
`endif

`endif

// ===== rtl/core/hsv565_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB565 package
// Shared constants, widths and the divider stage-enable type.
// ----------------------------------------------------------------------------
package hsv565_pkg;

	localparam int unsigned HueW     = 9;
	localparam int unsigned ChanW    = 8;
	localparam int unsigned SecW     = 3;
	localparam int unsigned RemW     = 6;
	localparam int unsigned KW       = 14;   // holds 0..15300
	localparam int unsigned XW       = 22;   // holds 0..255*15300
	localparam int unsigned RecipW   = 19;
	localparam int unsigned RecipSh  = 32;

	localparam logic [HueW-1:0]   HueWrap      = 9'd360;
	localparam logic [RemW-1:0]   DegPerSector = 6'd60;
	localparam logic [KW-1:0]     Scale        = 14'd15300;   // 255 * 60
	// floor(2^32 / 15300); the estimate it gives is low by at most one.
	localparam logic [RecipW-1:0] RecipScale   = 19'd280716;

	localparam int unsigned NumTerms = 3;

	// Per-stage load enables of the constant divider.
	typedef struct packed {
		logic s4;
		logic s5;
	} div_en_t;

endpackage

// ===== rtl/core/hsv565_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB565 constant divider
// Two-stage floor(x / 15300): reciprocal estimate, then one correction step.
// ----------------------------------------------------------------------------
module hsv565_div (
	input  logic                                 clk,
	input  hsv565_pkg::div_en_t                  en,
	input  logic [hsv565_pkg::XW-1:0]            x,
	output logic [hsv565_pkg::ChanW-1:0]         q
);

	localparam int unsigned PW = hsv565_pkg::XW + hsv565_pkg::RecipW;

	logic [PW-1:0]                   prod;
	logic [hsv565_pkg::ChanW-1:0]    q0_s4;
	logic [hsv565_pkg::XW-1:0]       x_s4;
	logic [hsv565_pkg::XW-1:0]       resid;
	logic [hsv565_pkg::ChanW-1:0]    q_s5;

	assign prod = PW'(x) * PW'(hsv565_pkg::RecipScale);

	// The estimate never exceeds 255 because x never exceeds 255 * 15300.
	always_ff @(posedge clk) begin
		if (en.s4) begin
			q0_s4 <= prod[hsv565_pkg::RecipSh +: hsv565_pkg::ChanW];
			x_s4  <= x;
		end
	end

	assign resid = x_s4 - (hsv565_pkg::XW'(q0_s4) * hsv565_pkg::XW'(hsv565_pkg::Scale));

	always_ff @(posedge clk) begin
		if (en.s5) begin
			if (resid >= hsv565_pkg::XW'(hsv565_pkg::Scale)) begin
				q_s5 <= q0_s4 + 8'd1;
			end else begin
				q_s5 <= q0_s4;
			end
		end
	end

	assign q = q_s5;

endmodule

// ===== rtl/core/hsv_to_rgb565_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB565 converter
// Six-stage pipeline turning one HSV pixel into a packed RGB565 word.
// ----------------------------------------------------------------------------
// The converter takes one pixel per clock while the output side keeps up and
// returns one RGB565 word per pixel, in order. The six register stages are
// the hue sector split, saturation terms, value multiply, two divider stages
// and the packed output register. Each stage has its own valid bit and loads
// whenever it is empty or its successor can move, so bubbles are squeezed out
// and a beat is still accepted while a finished word waits at the output, as
// long as some stage is empty. Hue values of 360 and above are read as 0
// degrees, and zero saturation gives a gray pixel equal to the value on all
// three channels.

`include "hsv_to_rgb565_top_macros.svh"

module hsv_to_rgb565_top (
	input  logic        clk,
	input  logic        arst_n,
	// Input beat: [8:0] hue_deg, [16:9] saturation, [24:17] brightness,
	// [31:25] zero.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,
	// Output beat: [15:0] rgb565.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata
);

	localparam int unsigned ChanW = hsv565_pkg::ChanW;
	localparam int unsigned KW    = hsv565_pkg::KW;
	localparam int unsigned XW    = hsv565_pkg::XW;
	localparam int unsigned SecW  = hsv565_pkg::SecW;
	localparam int unsigned RemW  = hsv565_pkg::RemW;
	localparam int unsigned HueW  = hsv565_pkg::HueW;

	// Sector codes around the hue circle.
	localparam logic [SecW-1:0] SecRed     = 3'd0;
	localparam logic [SecW-1:0] SecYellow  = 3'd1;
	localparam logic [SecW-1:0] SecGreen   = 3'd2;
	localparam logic [SecW-1:0] SecCyan    = 3'd3;
	localparam logic [SecW-1:0] SecBlue    = 3'd4;
	localparam logic [SecW-1:0] SecMagenta = 3'd5;

	// Term slots: flat, rising and falling.
	localparam int unsigned TermA = 0;
	localparam int unsigned TermC = 1;
	localparam int unsigned TermD = 2;

	// Stage load enables: a stage loads when it is empty or its successor moves.
	logic ld1, ld2, ld3, ld4, ld5, ld6;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	assign ld6 = !vld_s6 || m_tready;
	assign ld5 = !vld_s5 || ld6;
	assign ld4 = !vld_s4 || ld5;
	assign ld3 = !vld_s3 || ld4;
	assign ld2 = !vld_s2 || ld3;
	assign ld1 = !vld_s1 || ld2;

	assign s_tready = ld1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (ld1) vld_s1 <= s_tvalid;
			if (ld2) vld_s2 <= vld_s1;
			if (ld3) vld_s3 <= vld_s2;
			if (ld4) vld_s4 <= vld_s3;
			if (ld5) vld_s5 <= vld_s4;
			if (ld6) vld_s6 <= vld_s5;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: wrap the hue and split it into a sector and a remainder.
	// ------------------------------------------------------------------
	logic [HueW-1:0]  hue_in;
	logic [ChanW-1:0] sat_in;
	logic [ChanW-1:0] val_in;
	logic [HueW-1:0]  hue_c;
	logic [SecW-1:0]  sec_c;
	logic [HueW-1:0]  rem_c;

	assign hue_in = s_tdata[8:0];
	assign sat_in = s_tdata[16:9];
	assign val_in = s_tdata[24:17];

	always_comb begin
		hue_c = (hue_in >= hsv565_pkg::HueWrap) ? '0 : hue_in;
		if (hue_c >= 9'd300) begin
			sec_c = SecMagenta;
		end else if (hue_c >= 9'd240) begin
			sec_c = SecBlue;
		end else if (hue_c >= 9'd180) begin
			sec_c = SecCyan;
		end else if (hue_c >= 9'd120) begin
			sec_c = SecGreen;
		end else if (hue_c >= 9'd60) begin
			sec_c = SecYellow;
		end else begin
			sec_c = SecRed;
		end
		rem_c = hue_c - (HueW'(sec_c) * HueW'(hsv565_pkg::DegPerSector));
	end

	logic [SecW-1:0]  sec_s1;
	logic [RemW-1:0]  rem_s1;
	logic [ChanW-1:0] sat_s1;
	logic [ChanW-1:0] val_s1;
	logic             gray_s1;

	always_ff @(posedge clk) begin
		if (ld1) begin
			sec_s1  <= sec_c;
			rem_s1  <= rem_c[RemW-1:0];
			sat_s1  <= sat_in;
			val_s1  <= val_in;
			gray_s1 <= (sat_in == '0);
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: numerators over 15300. The flat term a = v*(255-s)/255 is
	// rewritten as v*(15300-60*s)/15300 so all three use the same divide by 15300.
	// ------------------------------------------------------------------
	logic [KW-1:0]    k_s2 [hsv565_pkg::NumTerms];
	logic [SecW-1:0]  sec_s2;
	logic [ChanW-1:0] val_s2;
	logic             gray_s2;
	logic [RemW-1:0]  rise_c;

	assign rise_c = hsv565_pkg::DegPerSector - rem_s1;

	always_ff @(posedge clk) begin
		if (ld2) begin
			k_s2[TermA] <= hsv565_pkg::Scale
				- (KW'(sat_s1) * KW'(hsv565_pkg::DegPerSector));
			k_s2[TermC] <= hsv565_pkg::Scale - (KW'(sat_s1) * KW'(rise_c));
			k_s2[TermD] <= hsv565_pkg::Scale - (KW'(sat_s1) * KW'(rem_s1));
			sec_s2      <= sec_s1;
			val_s2      <= val_s1;
			gray_s2     <= gray_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: scale each numerator by the value.
	// ------------------------------------------------------------------
	logic [XW-1:0]    x_s3 [hsv565_pkg::NumTerms];
	logic [SecW-1:0]  sec_s3;
	logic [ChanW-1:0] val_s3;
	logic             gray_s3;

	always_ff @(posedge clk) begin
		if (ld3) begin
			for (int i = 0; i < hsv565_pkg::NumTerms; i++) begin
				x_s3[i] <= XW'(val_s2) * XW'(k_s2[i]);
			end
			sec_s3  <= sec_s2;
			val_s3  <= val_s2;
			gray_s3 <= gray_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stages 4 and 5: divide each product by 15300.
	// ------------------------------------------------------------------
	hsv565_pkg::div_en_t div_en;
	logic [ChanW-1:0]    term [hsv565_pkg::NumTerms];

	assign div_en.s4 = ld4;
	assign div_en.s5 = ld5;

	for (genvar gi = 0; gi < hsv565_pkg::NumTerms; gi++) begin : g_div
		hsv565_div u_div (
			.clk (clk),
			.en  (div_en),
			.x   (x_s3[gi]),
			.q   (term[gi])
		);
	end

	logic [SecW-1:0]  sec_s4, sec_s5;
	logic [ChanW-1:0] val_s4, val_s5;
	logic             gray_s4, gray_s5;

	always_ff @(posedge clk) begin
		if (ld4) begin
			sec_s4  <= sec_s3;
			val_s4  <= val_s3;
			gray_s4 <= gray_s3;
		end
		if (ld5) begin
			sec_s5  <= sec_s4;
			val_s5  <= val_s4;
			gray_s5 <= gray_s4;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: pick the channels by sector and pack to 5/6/5 bits.
	// This register is also the output register of the stream.
	// ------------------------------------------------------------------
	logic [ChanW-1:0] red_c, grn_c, blu_c;
	logic [15:0]      rgb_s6;

	always_comb begin
		if (gray_s5) begin
			red_c = val_s5;
			grn_c = val_s5;
			blu_c = val_s5;
		end else begin
			unique case (sec_s5)
				SecRed: begin
					red_c = val_s5;       grn_c = term[TermC]; blu_c = term[TermA];
				end
				SecYellow: begin
					red_c = term[TermD];  grn_c = val_s5;      blu_c = term[TermA];
				end
				SecGreen: begin
					red_c = term[TermA];  grn_c = val_s5;      blu_c = term[TermC];
				end
				SecCyan: begin
					red_c = term[TermA];  grn_c = term[TermD]; blu_c = val_s5;
				end
				SecBlue: begin
					red_c = term[TermC];  grn_c = term[TermA]; blu_c = val_s5;
				end
				default: begin
					red_c = val_s5;       grn_c = term[TermA]; blu_c = term[TermD];
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ld6) begin
			rgb_s6 <= {red_c[7:3], grn_c[7:2], blu_c[7:3]};
		end
	end

	assign m_tvalid = vld_s6;
	assign m_tdata  = rgb_s6;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	// Input back-pressure only when every stage holds a pixel.
	`HSV565_ASSERT_IMP(a_full_stall, clk, arst_n, !s_tready,
		vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && vld_s6)
	// An accepted beat always lands in stage 1.
	`HSV565_ASSERT_NXT(a_accept_lands, clk, arst_n, s_tvalid && s_tready, vld_s1)
	// A waiting output word is never dropped by the pipeline.
	`HSV565_ASSERT_NXT(a_out_kept, clk, arst_n, vld_s6 && !m_tready, vld_s6)
	// The sector split keeps the remainder inside one sector.
	`HSV565_ASSERT_IMP(a_sector_split, clk, arst_n, vld_s1,
		(sec_s1 <= SecMagenta) && (rem_s1 < hsv565_pkg::DegPerSector))

endmodule

// ===== dv/hsv_to_rgb565_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB565 stream checker
// Predicts each output color from the accepted input beats and compares.
// ----------------------------------------------------------------------------
module hsv_to_rgb565_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,    // [8:0] hue_deg, [16:9] saturation, [24:17] brightness
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,    // [15:0] rgb565
	output int          mismatch_count,
	output int          colors_pending
);

	localparam int unsigned HueLimit   = 360;
	localparam int unsigned SectorDeg  = 60;
	localparam int unsigned FullScale  = 255;
	localparam int unsigned RampScale  = FullScale * SectorDeg;

	// Hue sectors, named after the channel that ramps inside each one.
	typedef enum logic [2:0] {
		SEC_RISE_G = 3'd0,
		SEC_FALL_R = 3'd1,
		SEC_RISE_B = 3'd2,
		SEC_FALL_G = 3'd3,
		SEC_RISE_R = 3'd4,
		SEC_FALL_B = 3'd5
	} hue_sector_e;

	logic [15:0] rgb565_expected [$];

	function automatic logic [15:0] predict_rgb565(input logic [8:0] hue,
		input logic [7:0] sat, input logic [7:0] val);
		int unsigned h;
		int unsigned s;
		int unsigned v;
		int unsigned rem;
		hue_sector_e sector;
		logic [7:0] flat;
		logic [7:0] fall;
		logic [7:0] rise;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		h = hue;
		s = sat;
		v = val;
		if (h >= HueLimit)
			h = 0;
		if (s == 0) begin
			r = val;
			g = val;
			b = val;
		end else begin
			sector = hue_sector_e'(3'(h / SectorDeg));
			rem    = h % SectorDeg;
			flat   = 8'(v * (FullScale - s) / FullScale);
			fall   = 8'(v * (RampScale - s * rem) / RampScale);
			rise   = 8'(v * (RampScale - s * (SectorDeg - rem)) / RampScale);
			case (sector)
				SEC_RISE_G: begin r = val;  g = rise; b = flat; end
				SEC_FALL_R: begin r = fall; g = val;  b = flat; end
				SEC_RISE_B: begin r = flat; g = val;  b = rise; end
				SEC_FALL_G: begin r = flat; g = fall; b = val;  end
				SEC_RISE_R: begin r = rise; g = flat; b = val;  end
				default:    begin r = val;  g = flat; b = fall; end
			endcase
		end
		return {r[7:3], g[7:2], b[7:3]};
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t: color check: %s", $realtime, what);
		mismatch_count++;
	endtask

	initial begin
		mismatch_count = 0;
		colors_pending = 0;
	end

	// Output is handled before input so a beat leaving and one entering on the
	// same edge are kept apart; the pipeline never returns a pixel that fast.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rgb565_expected.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (rgb565_expected.size() == 0)
					report_mismatch($sformatf("unexpected beat rgb565=%h", m_tdata));
				else if (m_tdata !== rgb565_expected[0])
					report_mismatch($sformatf("rgb565 got %h want %h",
						m_tdata, rgb565_expected.pop_front()));
				else
					void'(rgb565_expected.pop_front());
			end
			if (s_tvalid && s_tready)
				rgb565_expected.push_back(predict_rgb565(s_tdata[8:0],
					s_tdata[16:9], s_tdata[24:17]));
		end
		colors_pending = rgb565_expected.size();
	end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB565 converter testbench
// Drives directed and random pixels under varied flow control and checks
// every returned color against an independent prediction.
// ----------------------------------------------------------------------------
module tb;

	// Cycles with no beat on either side before the run is declared hung.
	// This limit is far beyond the longest wait between beats in any phase.
	localparam int WatchdogLimit = 2000;
	// Cycles to watch for stray beats once every expected color is back.
	localparam int SettleCycles  = 16;
	localparam int RandomPerPhase = 160;
	localparam int NumPhases      = 4;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [8:0] hue_deg, [16:9] saturation, [24:17] brightness
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // [15:0] rgb565

	int mismatch_count;
	int colors_pending;
	int idle_pct;
	int stall_pct;
	int quiet_cycles;

	// Per-phase flow control: free running, sparse input, heavy output
	// back-pressure, and both together at a lighter rate.
	int idle_by_phase  [NumPhases] = '{0, 81, 0, 23};
	int stall_by_phase [NumPhases] = '{0, 0, 81, 23};

	hsv_to_rgb565_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	hsv_to_rgb565_checker color_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.mismatch_count (mismatch_count),
		.colors_pending (colors_pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// The output side stalls at random according to the current phase.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Any beat on either side resets the hang counter.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WatchdogLimit) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Presents one pixel and returns right after the edge that takes it. A
	// random number of idle cycles may come first; valid stays high between
	// back-to-back pixels so it is never lowered and raised in one step.
	task automatic send_pixel(input logic [8:0] hue, input logic [7:0] sat,
		input logic [7:0] val);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, val, sat, hue};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Holds the input idle until every predicted color has come back. The
	// first edge lets the checker record the last beat taken.
	task automatic drain_colors();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (colors_pending != 0)
			@(posedge clk);
	endtask

	// Random channel level that favors the extremes.
	function automatic logic [7:0] random_level();
		int pick;
		pick = $urandom_range(99);
		if (pick < 8)
			return 8'd0;
		else if (pick < 16)
			return 8'd255;
		else
			return 8'($urandom_range(255));
	endfunction

	initial begin
		logic [8:0] hue;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		idle_pct     = 0;
		stall_pct    = 0;
		quiet_cycles = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pixels: sector edges at full saturation, the wrap of
		// out-of-range hues to zero, gray pixels and the channel extremes.
		send_pixel(9'd0,   8'd255, 8'd255);
		send_pixel(9'd59,  8'd255, 8'd255);
		send_pixel(9'd60,  8'd255, 8'd255);
		send_pixel(9'd119, 8'd255, 8'd255);
		send_pixel(9'd120, 8'd255, 8'd255);
		send_pixel(9'd179, 8'd200, 8'd255);
		send_pixel(9'd180, 8'd255, 8'd255);
		send_pixel(9'd240, 8'd255, 8'd255);
		send_pixel(9'd299, 8'd128, 8'd170);
		send_pixel(9'd300, 8'd255, 8'd255);
		send_pixel(9'd359, 8'd255, 8'd255);
		send_pixel(9'd360, 8'd255, 8'd255);
		send_pixel(9'd400, 8'd90,  8'd200);
		send_pixel(9'd511, 8'd255, 8'd255);
		send_pixel(9'd200, 8'd0,   8'd255);
		send_pixel(9'd37,  8'd0,   8'd129);
		send_pixel(9'd511, 8'd0,   8'd0);
		send_pixel(9'd90,  8'd1,   8'd255);
		send_pixel(9'd150, 8'd255, 8'd0);
		send_pixel(9'd270, 8'd255, 8'd1);
		send_pixel(9'd330, 8'd1,   8'd1);
		send_pixel(9'd45,  8'd127, 8'd128);
		drain_colors();

		// Random pixels, phase by phase, each phase drained before the next.
		for (int phase = 0; phase < NumPhases; phase++) begin
			idle_pct  = idle_by_phase[phase];
			stall_pct = stall_by_phase[phase];
			for (int n = 0; n < RandomPerPhase; n++) begin
				// Most hues are in range; some exercise the wrap to zero.
				if ($urandom_range(99) < 15)
					hue = 9'($urandom_range(511));
				else
					hue = 9'($urandom_range(359));
				send_pixel(hue, random_level(), random_level());
			end
			drain_colors();
		end

		// Watch a while longer for beats that were never predicted.
		repeat (SettleCycles) @(posedge clk);
		if (mismatch_count == 0 && colors_pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/hsv565_pkg.sv
rtl/core/hsv565_div.sv
rtl/core/hsv_to_rgb565_top.sv
dv/hsv_to_rgb565_checker.sv
dv/tb.sv
